// File: src/tkl_pkg.sv
// shared types and constants for the top-k largest tracker
package tkl_pkg;

    localparam int KEY_W  = 32;
    localparam int SIZE_W = 64;
    localparam int ENT_W  = KEY_W + SIZE_W;
    localparam int KEEP_W = 5;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd10;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    // key in the low bits, matching the stream data layout
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [KEY_W-1:0]  key;
    } entry_t;

    typedef struct packed {
        logic key_eq;
        logic size_ge;
    } cmp_res_t;

endpackage

// File: src/top_k_largest_tracker_top.sv
// An insert scans the list through the single read port and compare unit, then, unless
// the key is already stored or the item ranks below a full list, shifts entries down
// and writes the item into its place, with s_tready low throughout. A dump reads each
// result from memory, then loads it into the output register, waiting on output stalls.
// The next request is taken in the idle state, where s_tready is high.
// Reset clears the fill count, sets keep_count to 10 and leaves stored entries as they are.
module top_k_largest_tracker_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config register write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data,      // keep_count
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,       // item_key[31:0], item_size[95:32]
    input  logic         s_tuser,       // kind
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,       // out_key[31:0], out_size[95:32]
    output logic         m_tuser,       // out_valid
    output logic         m_tlast        // out_last
);
    import tkl_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES > 1 ? MAX_ENTRIES : 2);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = CNT_W > KEEP_W ? CNT_W : KEEP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DUMP_RD,
        ST_DUMP_LD
    } state_t;

    state_t              state_reg, state_next;
    logic [KEEP_W-1:0]   keep_reg, keep_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                dv_reg, dv_next;
    logic [CNT_W-1:0]    didx_reg, didx_next;
    logic                dup_reg, dup_next;
    logic                found_reg, found_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic                m_valid_reg, m_valid_next;
    entry_t              m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;
    logic                m_last_reg, m_last_next;

    logic                rd_en, wr_en;
    logic [IDX_W-1:0]    rd_addr, wr_addr;
    entry_t              wr_data, rd_data;
    cmp_res_t            cmp;

    logic [CMP_W-1:0]    keep_ext, cap_ext;
    logic [CNT_W-1:0]    cap, newcnt, pos_fin, didx_up;
    logic [CNT_W:0]      fill_inc;
    logic                out_free;

    tkl_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tkl_cmp u_cmp (
        .ent       (rd_data),
        .item_key  (key_reg),
        .item_size (size_reg),
        .res       (cmp)
    );

    // effective limit: 0 acts as 1, clamp to storage depth
    always_comb begin
        keep_ext = CMP_W'(keep_reg);
        if (keep_ext == '0) begin
            cap_ext = CMP_W'(1);
        end else if (keep_ext > CMP_W'(MAX_ENTRIES)) begin
            cap_ext = CMP_W'(MAX_ENTRIES);
        end else begin
            cap_ext = keep_ext;
        end
        cap      = cap_ext[CNT_W-1:0];
        fill_inc = {1'b0, fill_reg} + {{CNT_W{1'b0}}, 1'b1};
        newcnt   = (fill_inc > {1'b0, cap}) ? cap : fill_inc[CNT_W-1:0];
        pos_fin  = found_reg ? pos_reg : fill_reg;
        didx_up  = didx_reg + CNT_W'(1);
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        keep_next    = keep_reg;
        fill_next    = fill_reg;
        key_next     = key_reg;
        size_next    = size_reg;
        idx_next     = idx_reg;
        dv_next      = 1'b0;
        didx_next    = didx_reg;
        dup_next     = dup_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = didx_up[IDX_W-1:0];
        wr_data      = rd_data;

        if (cfg_valid) begin
            keep_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    key_next  = s_tdata[KEY_W-1:0];
                    size_next = s_tdata[ENT_W-1:KEY_W];
                    if (s_tuser == KIND_INSERT) begin
                        idx_next   = '0;
                        dup_next   = 1'b0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end else begin
                        idx_next   = fill_reg;
                        state_next = ST_DUMP_RD;
                    end
                end
            end
            ST_SCAN: begin
                // read one entry per cycle, compare the one read last cycle
                rd_en     = (idx_reg < fill_reg);
                rd_addr   = idx_reg[IDX_W-1:0];
                dv_next   = rd_en;
                didx_next = idx_reg;
                if (rd_en) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (dv_reg) begin
                    if (cmp.key_eq) begin
                        dup_next = 1'b1;
                    end
                    if (!cmp.size_ge && !found_reg) begin
                        found_next = 1'b1;
                        pos_next   = didx_reg;
                    end
                end
                if (!rd_en && !dv_reg) begin
                    if (dup_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        fill_next = newcnt;
                        pos_next  = pos_fin;
                        if (pos_fin < newcnt) begin
                            idx_next   = newcnt - CNT_W'(1);
                            state_next = ST_SHIFT;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_SHIFT: begin
                // move entries down one place, bottom first
                rd_en     = (idx_reg > pos_reg);
                didx_next = idx_reg - CNT_W'(1);
                rd_addr   = didx_next[IDX_W-1:0];
                dv_next   = rd_en;
                if (rd_en) begin
                    idx_next = idx_reg - CNT_W'(1);
                end
                if (dv_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = didx_up[IDX_W-1:0];
                    wr_data = rd_data;
                end else if (!rd_en) begin
                    wr_en        = 1'b1;
                    wr_addr      = pos_reg[IDX_W-1:0];
                    wr_data.key  = key_reg;
                    wr_data.size = size_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_DUMP_RD: begin
                didx_next  = idx_reg - CNT_W'(1);
                rd_en      = (idx_reg != '0);
                rd_addr    = didx_next[IDX_W-1:0];
                state_next = ST_DUMP_LD;
            end
            ST_DUMP_LD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (fill_reg == '0) begin
                        m_data_next = '0;
                        m_user_next = 1'b0;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        m_data_next = rd_data;
                        m_user_next = 1'b1;
                        m_last_next = (idx_reg == CNT_W'(1));
                        idx_next    = idx_reg - CNT_W'(1);
                        state_next  = (idx_reg == CNT_W'(1)) ? ST_IDLE : ST_DUMP_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            keep_reg    <= KEEP_RESET;
            fill_reg    <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            keep_reg    <= keep_next;
            fill_reg    <= fill_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg    <= key_next;
        size_reg   <= size_next;
        idx_reg    <= idx_next;
        didx_reg   <= didx_next;
        dup_reg    <= dup_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign m_tlast   = m_last_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count above storage depth");

    a_fill_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != $past(fill_reg)) |-> ($past(state_reg) == ST_SCAN))
        else $error("fill count changed outside the scan");

    a_dump_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP_RD || state_reg == ST_DUMP_LD) |-> !wr_en)
        else $error("list written during a dump");

    a_empty_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_user_reg) |-> m_last_reg)
        else $error("empty-list result not marked last");

endmodule

// File: src/tkl_mem.sv
// entry storage: one write port, one read port with registered data
module tkl_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  tkl_pkg::entry_t   wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output tkl_pkg::entry_t   rd_data
);
    import tkl_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/tkl_cmp.sv
// shared compare unit: key match and size ordering against one stored entry
module tkl_cmp (
    input  tkl_pkg::entry_t   ent,
    input  logic [31:0]       item_key,
    input  logic [63:0]       item_size,
    output tkl_pkg::cmp_res_t res
);
    import tkl_pkg::*;

    always_comb begin
        res.key_eq  = (ent.key == item_key);
        res.size_ge = (ent.size >= item_size);
    end

endmodule
